FILE: rtl/escaped_api_frame_receiver_assert.svh
// Assertion macros for the escaped API frame receiver.
// Used by escaped_api_frame_receiver.sv, which carries concurrent checks; needs nothing else.
`ifndef ESCAPED_API_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_API_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define EAFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define EAFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/eafr_pkg.sv
// Shared constants and types for the escaped API frame receiver.
// No dependencies; used by eafr_parse and escaped_api_frame_receiver.
`default_nettype none

package eafr_pkg;

   localparam logic [7:0] DELIM_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_XOR    = 8'h20;
   localparam logic [7:0] SUM_GOOD   = 8'hFF;

   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_END_GOOD = 2'd1;
   localparam logic [1:0] KIND_END_BAD  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] data_index;
      logic        frame_end;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/eafr_parse.sv
// Frame parser: delimiter/escape handling, length capture, running sum.
// Depends on eafr_pkg. Produces at most one result word per accepted byte.
`default_nettype none

module eafr_parse (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      take,
   input  wire  [7:0]               rx_byte,
   output logic                     res_valid,
   output eafr_pkg::result_type     res
);
   import eafr_pkg::*;

   logic        in_frame_ff, in_frame_in;
   logic        esc_ff, esc_in;
   logic [16:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  sum_ff, sum_in;

   logic [7:0]  byte_val;
   logic [16:0] data_end;
   logic [16:0] index_full;
   logic [7:0]  sum_check;

   assign byte_val   = esc_ff ? (rx_byte ^ ESC_XOR) : rx_byte;
   assign data_end   = {1'b0, len_ff} + 17'd2;
   assign index_full = pos_ff - 17'd2;
   assign sum_check  = sum_ff + byte_val;

   always_comb begin
      in_frame_in = in_frame_ff;
      esc_in      = esc_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      sum_in      = sum_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (take) begin
         priority if (rx_byte == DELIM_BYTE) begin
            // a delimiter restarts the frame unconditionally
            in_frame_in = 1'b1;
            esc_in      = 1'b0;
            pos_in      = '0;
            len_in      = '0;
            sum_in      = '0;
         end else if (!in_frame_ff) begin
            // drop bytes outside a frame
         end else if (rx_byte == ESC_BYTE) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            priority if (pos_ff == 17'd0) begin
               len_in = {byte_val, 8'h00};
               pos_in = 17'd1;
            end else if (pos_ff == 17'd1) begin
               len_in = {len_ff[15:8], byte_val};
               pos_in = 17'd2;
            end else if (pos_ff < data_end) begin
               res_valid      = 1'b1;
               res.kind       = KIND_DATA;
               res.data_byte  = byte_val;
               res.data_index = index_full[15:0];
               res.frame_end  = 1'b0;
               sum_in         = sum_check;
               pos_in         = pos_ff + 17'd1;
            end else begin
               // checksum byte closes the frame
               res_valid      = 1'b1;
               res.kind       = (sum_check == SUM_GOOD) ? KIND_END_GOOD : KIND_END_BAD;
               res.data_byte  = '0;
               res.data_index = len_ff;
               res.frame_end  = 1'b1;
               in_frame_in    = 1'b0;
               pos_in         = '0;
               sum_in         = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
         pos_ff      <= '0;
         len_ff      <= '0;
         sum_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/escaped_api_frame_receiver.sv
// A result word is registered in the output register that drives rsp_*, or in
// a one-word skid register while that output is stalled; one byte is taken per
// cycle while the skid word is empty, even while a result waits to be taken.
// Reset (synchronous, active high) clears the frame state and empties both
// result registers; the block waits for a delimiter afterwards.
`default_nettype none

module escaped_api_frame_receiver (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_data_index,
   output logic        rsp_frame_end
);
   import eafr_pkg::*;

   logic       take;
   logic       res_valid;
   result_type res;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;
   logic       out_load;

   // stall only when the skid word is occupied
   assign req_stall = skid_valid_ff;
   assign take      = req_valid && !req_stall;

   eafr_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   assign out_load = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_load) begin
         // advance: skid word first, else the fresh result
         out_valid_in  = skid_valid_ff || res_valid;
         out_in        = skid_valid_ff ? skid_ff : res;
         skid_valid_in = 1'b0;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_ff.kind;
   assign rsp_data_byte  = out_ff.data_byte;
   assign rsp_data_index = out_ff.data_index;
   assign rsp_frame_end  = out_ff.frame_end;

`include "escaped_api_frame_receiver_assert.svh"

   `EAFR_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid word held while output register empty")
   `EAFR_ASSERT_NOW(a_data_not_end, clock, reset,
      out_valid_ff && (out_ff.kind == KIND_DATA), !out_ff.frame_end,
      "data word flagged as frame end")
   `EAFR_ASSERT_NOW(a_end_no_byte, clock, reset,
      out_valid_ff && out_ff.frame_end, out_ff.data_byte == 8'h00,
      "end word carries a data byte")
   `EAFR_ASSERT_NEXT(a_skid_drains, clock, reset,
      skid_valid_ff && !rsp_stall, !skid_valid_ff,
      "skid word not drained after output taken")

endmodule

`default_nettype wire
